[hw/rtl/checksummed_block_checker_macros.svh]
// ---------------------------------------------------------------------------
// checksummed_block_checker_macros.svh
// Assertion macros used by the block checker assertion file.
// ---------------------------------------------------------------------------
`ifndef CHECKSUMMED_BLOCK_CHECKER_MACROS_SVH
`define CHECKSUMMED_BLOCK_CHECKER_MACROS_SVH

// clocked assertion, disabled while reset is low
`define CBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define CBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/cbc_pkg.sv]
// ---------------------------------------------------------------------------
// cbc_pkg
// Types, constants and the CRC-16 byte update for the block checker.
// ---------------------------------------------------------------------------
package cbc_pkg;

    localparam logic [7:0] BYTE_MASK = 8'hff;

    typedef enum logic [1:0] {
        HDR_CRC_LO = 2'd0,
        HDR_CRC_HI = 2'd1,
        HDR_REV    = 2'd2,
        HDR_DONE   = 2'd3
    } t_hdr_pos;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] crc_value;
        logic        crc_error;
        logic        revision_mismatch;
        logic        block_bad;
    } t_out_item;

    localparam logic REQ_VERIFY   = 1'b0;
    localparam logic REQ_GENERATE = 1'b1;

    // CRC-16, poly 0x1021, MSB first, one byte in xorshift form
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = {crc[7:0], crc[15:8]};
        c = c ^ {8'h00, b};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, (c[7:0] & BYTE_MASK), 5'b00000};
        return c;
    endfunction

endpackage

[hw/rtl/checksummed_block_checker.sv]
// ---------------------------------------------------------------------------
// checksummed_block_checker
// CRC-16 (XMODEM) over a byte stream; verifies a stored block header
// or produces the CRC for a header writer.
// ---------------------------------------------------------------------------
// channel  | handshake              | payload
// in       | i_in_valid / o_in_stall | i_in_item  (t_in_item)
// out      | o_out_valid / i_out_stall | o_out_item (t_out_item)
// cfg      | i_cfg_we               | i_cfg_data (expected revision)
//
// One item per cycle unless a held result stalls a last byte; a last byte
// passes the input register, then its result is held in the result register.
// Reset clears block state, pending items and expected revision.
// A stall on the result side only holds back a last byte; other bytes keep
// flowing while a result waits. Block state clears after every last byte.
// ---------------------------------------------------------------------------
module checksummed_block_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cbc_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cbc_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data
);
    import cbc_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic [7:0]  r_exp_rev;
    logic [15:0] r_crc;
    t_hdr_pos    r_hdr;
    logic [15:0] r_stored_crc;
    logic [7:0]  r_stored_rev;

    t_hdr_pos    n_hdr;
    logic [15:0] n_crc;
    logic [15:0] n_stored_crc;
    logic [7:0]  n_stored_rev;
    t_out_item   n_out_item;

    logic out_free;
    logic fire;
    logic crc_step;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && (!r_in_item.last_byte || out_free);
    assign o_in_stall = r_in_valid && !fire;

    // header position
    always_comb begin
        n_hdr = r_hdr;
        if (r_in_item.req_type == REQ_VERIFY) begin
            unique case (r_hdr)
                HDR_CRC_LO: n_hdr = HDR_CRC_HI;
                HDR_CRC_HI: n_hdr = HDR_REV;
                HDR_REV:    n_hdr = HDR_DONE;
                HDR_DONE:   n_hdr = HDR_DONE;
                default:    n_hdr = HDR_DONE;
            endcase
        end
    end

    // header capture, CRC and result
    always_comb begin
        n_stored_crc = r_stored_crc;
        n_stored_rev = r_stored_rev;
        crc_step     = (r_in_item.req_type == REQ_GENERATE) || (r_hdr == HDR_DONE);
        if (r_in_item.req_type == REQ_VERIFY) begin
            unique case (r_hdr)
                HDR_CRC_LO: n_stored_crc = {r_stored_crc[15:8], r_in_item.data_byte};
                HDR_CRC_HI: n_stored_crc = {r_in_item.data_byte, r_stored_crc[7:0]};
                HDR_REV:    n_stored_rev = r_in_item.data_byte;
                HDR_DONE:   n_stored_rev = r_stored_rev;
                default:    n_stored_rev = r_stored_rev;
            endcase
        end
        n_crc = crc_step ? crc16_byte(r_crc, r_in_item.data_byte) : r_crc;

        n_out_item                   = '0;
        n_out_item.crc_value         = n_crc;
        if (r_in_item.req_type == REQ_VERIFY) begin
            if (n_hdr != HDR_DONE) begin
                n_out_item.crc_error = 1'b1;
            end else begin
                n_out_item.crc_error         = (n_stored_crc != n_crc);
                n_out_item.revision_mismatch = (n_stored_rev != r_exp_rev);
            end
        end
        n_out_item.block_bad = n_out_item.crc_error | n_out_item.revision_mismatch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_exp_rev    <= '0;
            r_crc        <= '0;
            r_hdr        <= HDR_CRC_LO;
            r_stored_crc <= '0;
            r_stored_rev <= '0;
        end else begin
            if (i_cfg_we) begin
                r_exp_rev <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                if (r_in_item.last_byte) begin
                    r_crc        <= '0;
                    r_hdr        <= HDR_CRC_LO;
                    r_stored_crc <= '0;
                    r_stored_rev <= '0;
                end else begin
                    r_crc        <= n_crc;
                    r_hdr        <= n_hdr;
                    r_stored_crc <= n_stored_crc;
                    r_stored_rev <= n_stored_rev;
                end
            end
            if (fire && r_in_item.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (fire && r_in_item.last_byte) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[hw/rtl/cbc_checker.sv]
// ---------------------------------------------------------------------------
// cbc_checker
// Port-level assertions for the block checker, bound to the top level.
// ---------------------------------------------------------------------------
`include "checksummed_block_checker_macros.svh"

module cbc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input cbc_pkg::t_in_item   i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input cbc_pkg::t_out_item  o_out_item
);
    import cbc_pkg::*;

    `CBC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item), "stalled result changed")
    `CBC_ASSERT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item), "stalled input item changed")
    `CBC_ASSERT(a_bad_or, i_clk, i_rst_n, o_out_valid |-> (o_out_item.block_bad == (o_out_item.crc_error || o_out_item.revision_mismatch)), "block_bad is not the OR of the errors")
    `CBC_ASSERT(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall), "input stalled without a held result")
    `CBC_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "reset left an item pending")

endmodule

bind checksummed_block_checker cbc_checker u_cbc_checker (.*);
